@@ hdl/tensor_permute_address_generator_assert.svh @@
// Assertion macros used by the checker file of the permute address generator.
`ifndef TENSOR_PERMUTE_ADDRESS_GENERATOR_ASSERT_SVH
`define TENSOR_PERMUTE_ADDRESS_GENERATOR_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define TPAG_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define TPAG_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

@@ hdl/tpag_pkg.sv @@
// Shared constants, register codes and types of the permute address generator.
package tpag_pkg;

	// Fixed geometry of the datapath.
	localparam int unsigned HW_AXES      = 4;
	localparam int unsigned AXIS_W       = 2;
	localparam int unsigned RANK_W       = 3;
	localparam int unsigned SIZE_W       = 9;
	localparam int unsigned SIZE_REG_MAX = (1 << SIZE_W) - 1;
	localparam int unsigned PERM_W       = 8;
	localparam int unsigned VALUE_W      = 64;
	localparam int unsigned INDEX_W      = 32;

	// Configuration port.
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 9;

	// Default values of the top level parameters.
	localparam int unsigned DEF_MAX_RANK     = 4;
	localparam int unsigned DEF_MAX_DIM_SIZE = 256;

	// Register values after reset.
	localparam logic [RANK_W-1:0] RESET_RANK    = 3'd4;
	localparam logic [SIZE_W-1:0] RESET_SIZE    = 9'd1;
	localparam logic [PERM_W-1:0] RESET_PERM    = 8'd228;
	localparam logic              RESET_REVERSE = 1'b1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RANK    = 3'd0,
		REG_SIZE0   = 3'd1,
		REG_SIZE1   = 3'd2,
		REG_SIZE2   = 3'd3,
		REG_SIZE3   = 3'd4,
		REG_PERM    = 3'd5,
		REG_REVERSE = 3'd6
	} cfg_reg_t;

	// Status flags that travel with an element down the index chain.
	typedef struct packed {
		logic perm_error;
		logic last_elem;
	} idx_ctl_t;

	// Per destination axis selection given to one index cell.
	typedef struct packed {
		logic              active;
		logic [AXIS_W-1:0] axis;
	} axis_sel_t;

endpackage

@@ hdl/tpag_ifs.sv @@
// Channel interfaces of the permute address generator: elements, results, configuration.
interface tpag_in_if;
	import tpag_pkg::*;

	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] elem_value;

	modport source(output valid, output elem_value, input ready);
	modport sink(input valid, input elem_value, output ready);
endinterface

interface tpag_out_if;
	import tpag_pkg::*;

	logic               valid;
	logic               ready;
	logic [INDEX_W-1:0] dest_index;
	logic [VALUE_W-1:0] out_value;
	logic               perm_error;
	logic               last_elem;

	modport source(output valid, output dest_index, output out_value, output perm_error,
		output last_elem, input ready);
	modport sink(input valid, input dest_index, input out_value, input perm_error,
		input last_elem, output ready);
endinterface

interface tpag_cfg_if;
	import tpag_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

@@ hdl/tpag_digit_cell.sv @@
// One digit of the source index odometer, chained to its neighbors by a carry.
module tpag_digit_cell #(
	parameter int unsigned DIG_W = 8,
	parameter int unsigned SZ_W  = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             active,
	input  logic [SZ_W-1:0]  size,
	input  logic             carry_in,
	output logic             carry_out,
	output logic [DIG_W-1:0] digit
);
	import tpag_pkg::*;

	logic [DIG_W-1:0] digit_q;
	logic [SZ_W:0]    inc;
	logic             at_end;

	// A digit at or past the last position of its dimension rolls over.
	always_comb begin
		inc    = (SZ_W+1)'(digit_q) + (SZ_W+1)'(1);
		at_end = (inc >= {1'b0, size});
	end

	// Unused dimensions pass the carry on untouched.
	assign carry_out = carry_in && (!active || at_end);
	assign digit     = digit_q;

	// Advance on an accepted element when the carry comes in; unused dimensions are held at zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (step) begin
			if (!active) begin
				digit_q <= '0;
			end else if (carry_in) begin
				digit_q <= at_end ? '0 : inc[DIG_W-1:0];
			end
		end
	end

endmodule

@@ hdl/tpag_index_cell.sv @@
// One stage of the destination index chain: a Horner multiply-add for one destination axis.
module tpag_index_cell #(
	parameter int unsigned DIG_W = 8,
	parameter int unsigned SZ_W  = 9
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  tpag_pkg::axis_sel_t                     sel,
	input  logic [tpag_pkg::HW_AXES-1:0][SZ_W-1:0]  sizes,
	input  logic                                    up_valid,
	output logic                                    up_ready,
	input  logic [tpag_pkg::INDEX_W-1:0]            up_acc,
	input  logic [tpag_pkg::HW_AXES-1:0][DIG_W-1:0] up_digits,
	input  logic [tpag_pkg::VALUE_W-1:0]            up_value,
	input  tpag_pkg::idx_ctl_t                      up_ctl,
	output logic                                    dn_valid,
	input  logic                                    dn_ready,
	output logic [tpag_pkg::INDEX_W-1:0]            dn_acc,
	output logic [tpag_pkg::HW_AXES-1:0][DIG_W-1:0] dn_digits,
	output logic [tpag_pkg::VALUE_W-1:0]            dn_value,
	output tpag_pkg::idx_ctl_t                      dn_ctl
);
	import tpag_pkg::*;

	logic                             valid_q;
	logic [INDEX_W-1:0]               acc_q;
	logic [HW_AXES-1:0][DIG_W-1:0]    digits_q;
	logic [VALUE_W-1:0]               value_q;
	idx_ctl_t                         ctl_q;
	logic [SZ_W-1:0]                  size_pick;
	logic [DIG_W-1:0]                 digit_pick;
	logic [INDEX_W+SZ_W-1:0]          prod;
	logic [INDEX_W-1:0]               acc_next;

	// Scale the partial index by this axis size and add this axis digit; an inactive cell passes the index on unchanged.
	always_comb begin
		size_pick  = sizes[sel.axis];
		digit_pick = up_digits[sel.axis];
		prod       = (INDEX_W+SZ_W)'(up_acc) * (INDEX_W+SZ_W)'(size_pick);
		acc_next   = sel.active ? (prod[INDEX_W-1:0] + INDEX_W'(digit_pick)) : up_acc;
	end

	// The stage takes a new transaction whenever it is empty or draining.
	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	// Payload of the stage.
	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			acc_q    <= acc_next;
			digits_q <= up_digits;
			value_q  <= up_value;
			ctl_q    <= up_ctl;
		end
	end

	assign dn_valid  = valid_q;
	assign dn_acc    = acc_q;
	assign dn_digits = digits_q;
	assign dn_value  = value_q;
	assign dn_ctl    = ctl_q;

endmodule

@@ hdl/tensor_permute_address_generator.sv @@
// Tensor axis-permute address generator. Source elements are taken in row-major order,
// one per clock, and each leaves with its row-major flat index in the permuted tensor,
// its value unchanged, an error flag for an invalid permutation and a mark on the last
// element. Throughput is one element per cycle; every element passes through the four
// cells of the index chain, each a register stage that does a single 32 by 9 bit
// multiply-add for one destination axis. Back pressure on the results
// fills the chain stage by stage before the element side stalls. The source index
// odometer is a row of digit cells that advances on each accepted element and wraps after
// the last one; configuration writes do not clear it. Configuration is to be written only
// while no element is in flight; the configuration channel is always ready.
module tensor_permute_address_generator #(
	parameter int unsigned MAX_RANK     = tpag_pkg::DEF_MAX_RANK,
	parameter int unsigned MAX_DIM_SIZE = tpag_pkg::DEF_MAX_DIM_SIZE
) (
	input logic         clk,
	input logic         arst_n,
	tpag_in_if.sink     elements,
	tpag_out_if.source  results,
	tpag_cfg_if.sink    cfg
);
	import tpag_pkg::*;

	localparam int unsigned SIZE_CAP = (MAX_DIM_SIZE < SIZE_REG_MAX) ? MAX_DIM_SIZE
		: SIZE_REG_MAX;
	localparam int unsigned SZ_W     = $clog2(SIZE_CAP + 1);
	localparam int unsigned DIG_W    = $clog2(SIZE_CAP);
	localparam int unsigned RANK_CAP = (MAX_RANK < HW_AXES) ? MAX_RANK : HW_AXES;

	// Configuration registers.
	logic [RANK_W-1:0]              rank_q;
	logic [HW_AXES-1:0][SIZE_W-1:0] size_q;
	logic [PERM_W-1:0]              perm_q;
	logic                           reverse_q;

	// Derived configuration.
	logic [RANK_W-1:0]              rank_eff;
	logic [HW_AXES-1:0]             active;
	logic [HW_AXES-1:0][SZ_W-1:0]   size_eff;
	axis_sel_t [HW_AXES-1:0]        cell_sel;
	logic                           perm_err;

	// Odometer.
	logic                           step;
	logic [HW_AXES:0]               carry;
	logic [HW_AXES-1:0][DIG_W-1:0]  digits;

	// Index chain links; link zero is the element channel.
	logic [HW_AXES:0]                           vld;
	logic [HW_AXES:0]                           rdy;
	logic [HW_AXES:0][INDEX_W-1:0]              acc;
	logic [HW_AXES:0][HW_AXES-1:0][DIG_W-1:0]   dig;
	logic [HW_AXES:0][VALUE_W-1:0]              val;
	idx_ctl_t [HW_AXES:0]                       ctl;

	// Configuration writes; an index beyond the register list is dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q    <= RESET_RANK;
			size_q    <= {HW_AXES{RESET_SIZE}};
			perm_q    <= RESET_PERM;
			reverse_q <= RESET_REVERSE;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_RANK:    rank_q    <= cfg.data[RANK_W-1:0];
				REG_SIZE0:   size_q[0] <= cfg.data[SIZE_W-1:0];
				REG_SIZE1:   size_q[1] <= cfg.data[SIZE_W-1:0];
				REG_SIZE2:   size_q[2] <= cfg.data[SIZE_W-1:0];
				REG_SIZE3:   size_q[3] <= cfg.data[SIZE_W-1:0];
				REG_PERM:    perm_q    <= cfg.data[PERM_W-1:0];
				REG_REVERSE: reverse_q <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	// Rank is clamped to one at the bottom and to the axis limit at the top.
	always_comb begin
		if (rank_q == '0) begin
			rank_eff = RANK_W'(1);
		end else if (rank_q > RANK_W'(RANK_CAP)) begin
			rank_eff = RANK_W'(RANK_CAP);
		end else begin
			rank_eff = rank_q;
		end
	end

	// Sizes are clamped; dimensions beyond the rank count as size one.
	always_comb begin
		for (int d = 0; d < HW_AXES; d++) begin
			active[d] = (RANK_W'(d) < rank_eff);
			if (!active[d] || size_q[d] == '0) begin
				size_eff[d] = SZ_W'(1);
			end else if (size_q[d] > SIZE_W'(SIZE_CAP)) begin
				size_eff[d] = SZ_W'(SIZE_CAP);
			end else begin
				size_eff[d] = SZ_W'(size_q[d]);
			end
		end
	end

	// Source axis of each destination axis, with range and duplicate checks.
	always_comb begin
		logic [HW_AXES-1:0] used;
		logic [RANK_W-1:0]  rev_axis;
		logic [RANK_W-1:0]  src_axis;
		used     = '0;
		perm_err = 1'b0;
		rev_axis = '0;
		src_axis = '0;
		for (int j = 0; j < HW_AXES; j++) begin
			rev_axis = rank_eff - RANK_W'(1) - RANK_W'(j);
			src_axis = reverse_q ? rev_axis : RANK_W'(perm_q[AXIS_W*j +: AXIS_W]);
			if (active[j]) begin
				if (src_axis >= rank_eff || used[src_axis[AXIS_W-1:0]]) begin
					perm_err = 1'b1;
				end else begin
					used[src_axis[AXIS_W-1:0]] = 1'b1;
				end
			end
			cell_sel[j].active = active[j];
			cell_sel[j].axis   = src_axis[AXIS_W-1:0];
		end
	end

	// Odometer: the carry enters at the innermost digit and ripples outward.
	assign step             = elements.valid && elements.ready;
	assign carry[HW_AXES]   = 1'b1;

	for (genvar d = 0; d < HW_AXES; d++) begin : g_digit
		tpag_digit_cell #(
			.DIG_W(DIG_W),
			.SZ_W (SZ_W)
		) u_digit (
			.clk      (clk),
			.arst_n   (arst_n),
			.step     (step),
			.active   (active[d]),
			.size     (size_eff[d]),
			.carry_in (carry[d+1]),
			.carry_out(carry[d]),
			.digit    (digits[d])
		);
	end

	// Head of the index chain: the element transaction with the current digits.
	assign vld[0]              = elements.valid;
	assign elements.ready      = rdy[0];
	assign acc[0]              = '0;
	assign dig[0]              = digits;
	assign val[0]              = elements.elem_value;
	assign ctl[0].perm_error   = perm_err;
	assign ctl[0].last_elem    = carry[0];

	for (genvar j = 0; j < HW_AXES; j++) begin : g_index
		tpag_index_cell #(
			.DIG_W(DIG_W),
			.SZ_W (SZ_W)
		) u_index (
			.clk      (clk),
			.arst_n   (arst_n),
			.sel      (cell_sel[j]),
			.sizes    (size_eff),
			.up_valid (vld[j]),
			.up_ready (rdy[j]),
			.up_acc   (acc[j]),
			.up_digits(dig[j]),
			.up_value (val[j]),
			.up_ctl   (ctl[j]),
			.dn_valid (vld[j+1]),
			.dn_ready (rdy[j+1]),
			.dn_acc   (acc[j+1]),
			.dn_digits(dig[j+1]),
			.dn_value (val[j+1]),
			.dn_ctl   (ctl[j+1])
		);
	end

	// The last cell is the output register; an invalid permutation gives index zero.
	assign results.valid      = vld[HW_AXES];
	assign rdy[HW_AXES]       = results.ready;
	assign results.dest_index = ctl[HW_AXES].perm_error ? '0 : acc[HW_AXES];
	assign results.out_value  = val[HW_AXES];
	assign results.perm_error = ctl[HW_AXES].perm_error;
	assign results.last_elem  = ctl[HW_AXES].last_elem;

endmodule

@@ hdl/tpag_checker.sv @@
// Port level checks of the permute address generator and their binding to the top level.
`include "tensor_permute_address_generator_assert.svh"

module tpag_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [tpag_pkg::INDEX_W-1:0] dest_index,
	input logic [tpag_pkg::VALUE_W-1:0] out_value,
	input logic                         perm_error,
	input logic                         last_elem
);
	import tpag_pkg::*;

	// A stalled result transaction keeps its valid and its payload.
	`TPAG_ASSERT(a_result_held, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(dest_index) && $stable(out_value) && $stable(perm_error) && $stable(last_elem), "stalled result changed")

	// An invalid permutation always reports index zero.
	`TPAG_ASSERT(a_error_zero_index, clk, arst_n, out_valid && perm_error |-> dest_index == '0, "error result with nonzero index")

	// With no result waiting the whole chain drains, so elements are taken.
	`TPAG_ASSERT(a_ready_when_drained, clk, arst_n, !out_valid |-> in_ready, "element side stalled with empty output")

	// Reset empties the output register.
	`TPAG_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> !out_valid, "result valid during reset")

endmodule

bind tensor_permute_address_generator tpag_checker u_tpag_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (elements.valid),
	.in_ready  (elements.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.dest_index(results.dest_index),
	.out_value (results.out_value),
	.perm_error(results.perm_error),
	.last_elem (results.last_elem)
);
